FILE: rtl/rfcs_pkg.sv
// Shared types and constants for the radial falloff circle shader.
`default_nettype none
package rfcs_pkg;

	localparam int ALU_W     = 28;
	localparam int SQ_STEPS  = 14;
	localparam int DIV_STEPS = 8;
	localparam int SQ_TOP    = 26;
	localparam logic [7:0] CH_MAX = 8'd255;

	typedef struct packed {
		logic [7:0] cx;
		logic [7:0] cy;
		logic [5:0] rad;
		logic [7:0] red;
		logic [7:0] grn;
		logic [7:0] blu;
	} circle_t;

	typedef struct packed {
		logic             ge;
		logic [ALU_W-1:0] diff;
	} alu_res_t;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_RD    = 13'b0000000000010,
		S_FETCH = 13'b0000000000100,
		S_DX    = 13'b0000000001000,
		S_DY    = 13'b0000000010000,
		S_RSQ   = 13'b0000000100000,
		S_CHK   = 13'b0000001000000,
		S_SQ    = 13'b0000010000000,
		S_DIFF  = 13'b0000100000000,
		S_MUL   = 13'b0001000000000,
		S_DIV   = 13'b0010000000000,
		S_ACC   = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/radial_falloff_circle_shader.sv
// Top level: circle table, sequencer and shared arithmetic of the circle shader.
// Load beat: written to the table on acceptance, no result.
// Shade beat: per active circle, fetch, square dx, dy and radius, then check range;
// if outside, skip it; if inside, 14 root steps, then per channel multiply, divide, add.
// One item at a time; input ready again once the result beat is taken.
// Reset clears control state and count_q; the circle table is not cleared.
`default_nettype none
module radial_falloff_circle_shader #(
	parameter int MAX_CIRCLES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       opcode,
	input  wire logic [6:0] entry_index,
	input  wire logic [7:0] center_x,
	input  wire logic [7:0] center_y,
	input  wire logic [5:0] radius,
	input  wire logic [7:0] circle_red,
	input  wire logic [7:0] circle_green,
	input  wire logic [7:0] circle_blue,
	input  wire logic [7:0] pixel_x,
	input  wire logic [7:0] pixel_y,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      pixel_red,
	output logic [7:0]      pixel_green,
	output logic [7:0]      pixel_blue
);
	import rfcs_pkg::*;

	localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;

	circle_t          mem [MAX_CIRCLES];
	circle_t          ent_q;
	state_t           state_q;
	logic [7:0]       count_q;
	logic [7:0]       n_q;
	logic [7:0]       k_q;
	logic [7:0]       px_q;
	logic [7:0]       py_q;
	logic [7:0]       dy_q;
	logic [16:0]      sumsq_q;
	logic [11:0]      rad2_q;
	logic [ALU_W-1:0] v_q;
	logic [ALU_W-1:0] res_q;
	logic [ALU_W-1:0] bit_q;
	logic [3:0]       it_q;
	logic [13:0]      span_q;
	logic [7:0]       q_q;
	logic [1:0]       ch_q;
	logic [7:0]       acc_q [3];

	logic             in_acc;
	logic             ld_we;
	logic [13:0]      rf;
	logic [7:0]       dx;
	logic [7:0]       dy;
	logic [13:0]      mul_a;
	logic [7:0]       mul_b;
	logic [21:0]      prod;
	logic [7:0]       col;
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	alu_res_t         alu;
	logic [8:0]       acc_sum;
	logic [7:0]       acc_cur;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_acc    = in_valid && in_ready;
	assign ld_we     = in_acc && !opcode && (32'(entry_index) < MAX_CIRCLES);
	assign pixel_red   = acc_q[0];
	assign pixel_green = acc_q[1];
	assign pixel_blue  = acc_q[2];

	assign rf = {ent_q.rad, 8'd0};
	assign dx = (px_q >= ent_q.cx) ? px_q - ent_q.cx : ent_q.cx - px_q;
	assign dy = (py_q >= ent_q.cy) ? py_q - ent_q.cy : ent_q.cy - py_q;

	always_comb begin
		unique case (ch_q)
			2'd0:    col = ent_q.red;
			2'd1:    col = ent_q.grn;
			default: col = ent_q.blu;
		endcase
		unique case (ch_q)
			2'd0:    acc_cur = acc_q[0];
			2'd1:    acc_cur = acc_q[1];
			default: acc_cur = acc_q[2];
		endcase
	end

	always_comb begin
		priority if (state_q == S_DX) begin
			mul_a = 14'(dx);
			mul_b = dx;
		end else if (state_q == S_DY) begin
			mul_a = 14'(dy_q);
			mul_b = dy_q;
		end else if (state_q == S_RSQ) begin
			mul_a = 14'(ent_q.rad);
			mul_b = 8'(ent_q.rad);
		end else begin
			mul_a = span_q;
			mul_b = col;
		end
	end
	assign prod = 22'(mul_a) * 22'(mul_b);

	always_comb begin
		if (state_q == S_SQ) begin
			alu_a = v_q;
			alu_b = res_q | bit_q;
		end else begin
			alu_a = v_q;
			alu_b = ALU_W'(rf) << it_q[2:0];
		end
	end

	rfcs_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	assign acc_sum = 9'(acc_cur) + 9'(q_q);

	always_ff @(posedge clk) begin
		if (ld_we) begin
			mem[AW'(entry_index)] <= '{cx: center_x, cy: center_y, rad: radius,
				red: circle_red, grn: circle_green, blu: circle_blue};
		end
		ent_q <= mem[AW'(k_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			it_q    <= '0;
			ch_q    <= '0;
			acc_q   <= '{default: '0};
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && opcode) begin
						px_q  <= pixel_x;
						py_q  <= pixel_y;
						n_q   <= (32'(count_q) > MAX_CIRCLES) ? 8'(MAX_CIRCLES) : count_q;
						k_q   <= '0;
						acc_q <= '{default: '0};
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= (k_q < n_q) ? S_FETCH : S_OUT;
				end
				S_FETCH: begin
					state_q <= S_DX;
				end
				S_DX: begin
					sumsq_q <= 17'(prod);
					dy_q    <= dy;
					state_q <= S_DY;
				end
				S_DY: begin
					sumsq_q <= sumsq_q + 17'(prod);
					state_q <= S_RSQ;
				end
				S_RSQ: begin
					rad2_q  <= 12'(prod);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if ((ent_q.rad == '0) || (sumsq_q >= 17'(rad2_q))) begin
						k_q     <= k_q + 8'd1;
						state_q <= S_RD;
					end else begin
						v_q     <= {sumsq_q[11:0], 16'd0};
						res_q   <= '0;
						bit_q   <= ALU_W'(1) << SQ_TOP;
						it_q    <= 4'(SQ_STEPS - 1);
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (alu.ge) begin
						v_q   <= alu.diff;
						res_q <= (res_q >> 1) | bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					it_q  <= it_q - 4'd1;
					if (it_q == '0) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					span_q  <= rf - res_q[13:0];
					ch_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					v_q     <= ALU_W'(prod);
					q_q     <= '0;
					it_q    <= 4'(DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (alu.ge) begin
						v_q <= alu.diff;
					end
					q_q  <= {q_q[6:0], alu.ge};
					it_q <= it_q - 4'd1;
					if (it_q == '0) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					acc_q[ch_q] <= acc_sum[8] ? CH_MAX : acc_sum[7:0];
					if (ch_q == 2'd2) begin
						k_q     <= k_q + 8'd1;
						state_q <= S_RD;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while result pending");
	a_shade_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && opcode) |=> !in_ready) else $error("shade beat did not start work");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !opcode) |=> in_ready) else $error("load beat left block busy");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (k_q <= n_q)) else $error("circle index ran past count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_red)))
		else $error("result dropped before taken");

endmodule
`default_nettype wire

FILE: rtl/rfcs_alu.sv
// Shared compare and subtract unit for square root and division steps.
`default_nettype none
module rfcs_alu (
	input  wire logic [rfcs_pkg::ALU_W-1:0] a,
	input  wire logic [rfcs_pkg::ALU_W-1:0] b,
	output rfcs_pkg::alu_res_t              res
);
	import rfcs_pkg::*;

	always_comb begin
		res.ge   = (a >= b);
		res.diff = a - b;
	end

endmodule
`default_nettype wire

FILE: verif/radial_falloff_circle_shader_check.sv
// Checker for the circle shader: tracks the table and count, predicts pixel beats and compares.
module radial_falloff_circle_shader_check
	import rfcs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic       opcode,
	input  wire logic [6:0] entry_index,
	input  wire logic [7:0] center_x,
	input  wire logic [7:0] center_y,
	input  wire logic [5:0] radius,
	input  wire logic [7:0] circle_red,
	input  wire logic [7:0] circle_green,
	input  wire logic [7:0] circle_blue,
	input  wire logic [7:0] pixel_x,
	input  wire logic [7:0] pixel_y,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] pixel_red,
	input  wire logic [7:0] pixel_green,
	input  wire logic [7:0] pixel_blue,
	output int              fail_count,
	output int              colours_pending,
	output int              pixels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 128;
	localparam logic OP_LOAD  = 1'b0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] grn;
		logic [7:0] blu;
	} colour_t;

	circle_t    circles [TABLE_DEPTH];
	logic [7:0] active_count;
	colour_t    colour_queue [$];

	function automatic longint unsigned root_fixed(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] add_sat(input logic [7:0] acc, input longint unsigned add);
		longint unsigned s;
		s = acc + add;
		return (s > CH_MAX) ? CH_MAX : s[7:0];
	endfunction

	function automatic colour_t shade_colour(input logic [7:0] px, input logic [7:0] py);
		colour_t         acc;
		int              n;
		longint unsigned rf, dx, dy, d;
		circle_t         c;
		acc = '0;
		n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
		for (int k = 0; k < n; k++) begin
			c = circles[k];
			rf = longint'(c.rad) << 8;
			if (rf == 0)
				continue;
			dx = (px >= c.cx) ? px - c.cx : c.cx - px;
			dy = (py >= c.cy) ? py - c.cy : c.cy - py;
			d = root_fixed((dx * dx + dy * dy) << 16);
			if (d >= rf)
				continue;
			acc.red = add_sat(acc.red, (c.red * (rf - d)) / rf);
			acc.grn = add_sat(acc.grn, (c.grn * (rf - d)) / rf);
			acc.blu = add_sat(acc.blu, (c.blu * (rf - d)) / rf);
		end
		return acc;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("MISMATCH %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		fail_count++;
	endtask

	assign colours_pending = colour_queue.size();

	always @(posedge clk or negedge arst_n) begin
		colour_t want;
		if (!arst_n) begin
			active_count <= '0;
			colour_queue.delete();
			fail_count = 0;
			pixels_checked = 0;
			for (int k = 0; k < TABLE_DEPTH; k++)
				circles[k] = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (colour_queue.size() == 0) begin
					$display("MISMATCH unexpected pixel beat at %0t", $realtime);
					fail_count++;
				end else begin
					want = colour_queue.pop_front();
					pixels_checked++;
					if (pixel_red !== want.red)
						report_mismatch("pixel_red", pixel_red, want.red);
					if (pixel_green !== want.grn)
						report_mismatch("pixel_green", pixel_green, want.grn);
					if (pixel_blue !== want.blu)
						report_mismatch("pixel_blue", pixel_blue, want.blu);
				end
			end
			if (in_valid && in_ready) begin
				if (opcode == OP_LOAD)
					circles[entry_index] = '{cx: center_x, cy: center_y, rad: radius,
						red: circle_red, grn: circle_green, blu: circle_blue};
				else
					colour_queue.push_back(shade_colour(pixel_x, pixel_y));
			end
			if (cfg_we)
				active_count <= cfg_data;
		end
	end
endmodule

FILE: verif/radial_falloff_circle_shader_test.sv
// Testbench top for the circle shader: stimulus, flow control, watchdog and verdict.
module radial_falloff_circle_shader_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SHADE = 1'b1;
	localparam int   STALL_LIMIT = 50000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       opcode = OP_LOAD;
	logic [6:0] entry_index = '0;
	logic [7:0] center_x = '0, center_y = '0;
	logic [5:0] radius = '0;
	logic [7:0] circle_red = '0, circle_green = '0, circle_blue = '0;
	logic [7:0] pixel_x = '0, pixel_y = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] pixel_red, pixel_green, pixel_blue;

	int fail_count, colours_pending, pixels_checked;
	int tx_idle_pct = 10, rx_idle_pct = 68;
	int stall_cycles = 0;
	int loads_sent = 0, shades_sent = 0, settings_used = 0;
	logic [7:0] cur_count = '0;
	logic [7:0] cx_copy [128];
	logic [7:0] cy_copy [128];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	radial_falloff_circle_shader u_top (.*);

	radial_falloff_circle_shader_check u_check (.*);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("radial_falloff_circle_shader_test: done, errors");
			$finish;
		end
	end

	task automatic send_beat(input logic op, input logic [6:0] idx, input logic [7:0] x,
			input logic [7:0] y, input logic [5:0] r, input logic [7:0] cr,
			input logic [7:0] cg, input logic [7:0] cb, input logic [7:0] px,
			input logic [7:0] py);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		center_x <= x;
		center_y <= y;
		radius <= r;
		circle_red <= cr;
		circle_green <= cg;
		circle_blue <= cb;
		pixel_x <= px;
		pixel_y <= py;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (op == OP_LOAD) begin
			cx_copy[idx] = x;
			cy_copy[idx] = y;
			loads_sent++;
		end else begin
			shades_sent++;
		end
	endtask

	task automatic load_circle(input logic [6:0] idx, input logic [7:0] x, input logic [7:0] y,
			input logic [5:0] r, input logic [7:0] cr, input logic [7:0] cg,
			input logic [7:0] cb);
		send_beat(OP_LOAD, idx, x, y, r, cr, cg, cb, 8'($urandom), 8'($urandom));
	endtask

	task automatic shade_pixel(input logic [7:0] px, input logic [7:0] py);
		send_beat(OP_SHADE, 7'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), px, py);
	endtask

	task automatic set_count(input logic [7:0] n);
		in_valid <= 1'b0;
		while (colours_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_count = n;
		settings_used++;
	endtask

	function automatic logic [7:0] near(input logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(140)) - 70;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	task automatic random_beat();
		int k, lim;
		lim = (cur_count > 128) ? 128 : cur_count;
		if ($urandom_range(99) < 15) begin
			load_circle(7'($urandom), 8'($urandom), 8'($urandom),
				($urandom_range(9) == 0) ? 6'd0 : 6'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		end else if (lim > 0 && $urandom_range(99) < 80) begin
			k = $urandom_range(lim - 1);
			shade_pixel(near(cx_copy[k]), near(cy_copy[k]));
		end else begin
			shade_pixel(8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [7:0] counts [12] = '{8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd12, 8'd128, 8'd20,
			8'd255, 8'd0, 8'd6, 8'd40};
		int beats;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < 128; k++)
			load_circle(7'(k), 8'($urandom), 8'($urandom), 6'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));

		load_circle(0, 8'd0, 8'd0, 6'd63, 8'd255, 8'd255, 8'd255);
		load_circle(1, 8'd0, 8'd0, 6'd0, 8'd255, 8'd255, 8'd255);
		load_circle(2, 8'd255, 8'd255, 6'd1, 8'd1, 8'd128, 8'd255);
		load_circle(3, 8'd10, 8'd0, 6'd63, 8'd200, 8'd200, 8'd200);
		load_circle(127, 8'd255, 8'd0, 6'd63, 8'd0, 8'd0, 8'd0);
		set_count(8'd4);
		shade_pixel(8'd0, 8'd0);
		shade_pixel(8'd63, 8'd0);
		shade_pixel(8'd62, 8'd0);
		shade_pixel(8'd5, 8'd0);
		shade_pixel(8'd255, 8'd255);
		shade_pixel(8'd255, 8'd254);
		shade_pixel(8'd128, 8'd128);
		shade_pixel(8'd0, 8'd255);
		set_count(8'd0);
		shade_pixel(8'd0, 8'd0);
		set_count(8'd255);
		shade_pixel(8'd255, 8'd0);
		shade_pixel(8'd0, 8'd0);

		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				tx_idle_pct = 68;
				rx_idle_pct = 10;
			end else if (p == 8) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_count(counts[p]);
			beats = (counts[p] >= 128) ? 12 : 145;
			repeat (beats) random_beat();
		end

		in_valid <= 1'b0;
		while (colours_pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		$display("covered %0d loads and %0d pixels (%0d checked) over %0d count settings",
			loads_sent, shades_sent, pixels_checked, settings_used);
		if (fail_count == 0 && colours_pending == 0)
			$display("radial_falloff_circle_shader_test: done, clean");
		else
			$display("radial_falloff_circle_shader_test: done, errors");
		$finish;
	end
endmodule

FILE: sim.f
rtl/rfcs_pkg.sv
rtl/rfcs_alu.sv
rtl/radial_falloff_circle_shader.sv
verif/radial_falloff_circle_shader_check.sv
verif/radial_falloff_circle_shader_test.sv
